>>> hw/rtl/checksum_frame_parser_fan_command_defines.svh
// Assertion macros shared by the frame parser checker.
// No dependencies; the using module must provide clk and rst.
`ifndef CHECKSUM_FRAME_PARSER_FAN_COMMAND_DEFINES_SVH
`define CHECKSUM_FRAME_PARSER_FAN_COMMAND_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/cfp_pkg.sv
// Shared types, constants and tables for the frame parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package cfp_pkg;

  // Width of the PWM compare value
  localparam int DUTY_BITS = 10;
  localparam int DUTY_FULL = (1 << DUTY_BITS) - 1;
  localparam logic [6:0] DUTY_MAX = 7'd100;

  // Reciprocal of 100 scaled by the full-scale value; exact for 0..100 percent
  localparam int DUTY_SHIFT = 22;
  localparam longint DUTY_RECIP_WIDE = ((longint'(DUTY_FULL) << DUTY_SHIFT) + 99) / 100;
  localparam logic [31:0] DUTY_RECIP = 32'(DUTY_RECIP_WIDE);
  localparam int DUTY_PROD_BITS = 40;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

  // Reply frame sequencing
  localparam int REPLY_LEN = 6;
  localparam int BEAT_BITS = $clog2(REPLY_LEN);
  localparam logic [BEAT_BITS-1:0] REPLY_LAST = BEAT_BITS'(REPLY_LEN - 1);

  // Configuration register indexes
  localparam logic [1:0] REG_HEADER_FIRST = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [1:0] REG_DUTY_LIMIT = 2'd2;

  // Register reset values
  localparam logic [7:0] HEADER_FIRST_RST = 8'hAA;
  localparam logic [7:0] HEADER_SECOND_RST = 8'h66;
  localparam logic [6:0] DUTY_LIMIT_RST = 7'd100;

  // Payload command codes
  localparam logic [7:0] CMD_QUERY = 8'h00;
  localparam logic [7:0] CMD_FAN_SET = 8'h01;
  localparam logic [7:0] PAYLOAD_LEN_CMD = 8'd2;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_REPLY  = 2'd1,
    KIND_FAN    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  // One classified frame waiting for the back end
  typedef struct packed {
    kind_t      kind;
    logic       fan_on;
    logic [6:0] duty;
  } cmd_entry_t;

  // Queue status seen by its neighbors
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // Percent to compare value, quotient truncated; percent is at most 100
  function automatic logic [DUTY_BITS-1:0] duty_code_of(input logic [6:0] pct);
    logic [DUTY_PROD_BITS-1:0] prod;
    prod = DUTY_PROD_BITS'(pct) * DUTY_PROD_BITS'(DUTY_RECIP);
    return prod[DUTY_SHIFT +: DUTY_BITS];
  endfunction

  // Fixed reply frame AA 66 02 80 01 81
  function automatic logic [7:0] reply_byte_of(input logic [BEAT_BITS-1:0] beat);
    logic [7:0] b;
    case (beat)
      3'd0:    b = 8'hAA;
      3'd1:    b = 8'h66;
      3'd2:    b = 8'h02;
      3'd3:    b = 8'h80;
      3'd4:    b = 8'h01;
      3'd5:    b = 8'h81;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> hw/rtl/cfp_front.sv
// Front end: configuration registers, header hunt, length/payload/checksum
// parsing and frame classification. Depends on cfp_pkg.
`timescale 1ns / 1ps

module cfp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                accept,
  input  logic [7:0]          byte_value,
  output logic                q_push,
  output cfp_pkg::cmd_entry_t q_entry
);

  typedef enum logic [4:0] {
    PH_HUNT1   = 5'b00001,
    PH_HUNT2   = 5'b00010,
    PH_LEN     = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CHECK   = 5'b10000
  } phase_t;

  phase_t     parse_phase, parse_phase_next;
  logic [7:0] header_first, header_second;
  logic [6:0] duty_limit;
  logic [7:0] frame_length, payload_count, running_sum;
  logic [7:0] command_byte, data_byte;
  logic       fan_power;
  logic [6:0] duty_held;

  logic [7:0] count_inc;
  logic [6:0] lim, clamped;
  logic       is_query, is_fan, sum_ok;

  // Write configuration registers; unknown index is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= cfp_pkg::HEADER_FIRST_RST;
      header_second <= cfp_pkg::HEADER_SECOND_RST;
      duty_limit    <= cfp_pkg::DUTY_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cfp_pkg::REG_HEADER_FIRST:  header_first  <= cfg_data;
        cfp_pkg::REG_HEADER_SECOND: header_second <= cfg_data;
        cfp_pkg::REG_DUTY_LIMIT:    duty_limit    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Classify the frame on its checksum byte
  assign count_inc = payload_count + 8'd1;
  assign lim       = (duty_limit > cfp_pkg::DUTY_MAX) ? cfp_pkg::DUTY_MAX : duty_limit;
  assign clamped   = (data_byte > {1'b0, lim}) ? lim : data_byte[6:0];
  assign sum_ok    = (byte_value == running_sum);
  assign is_query  = (frame_length == cfp_pkg::PAYLOAD_LEN_CMD) &&
                     (command_byte == cfp_pkg::CMD_QUERY) && (data_byte == cfp_pkg::CMD_QUERY);
  assign is_fan    = (frame_length == cfp_pkg::PAYLOAD_LEN_CMD) &&
                     (command_byte == cfp_pkg::CMD_FAN_SET);

  always_comb begin
    q_entry.kind   = cfp_pkg::KIND_STATUS;
    q_entry.fan_on = fan_power;
    q_entry.duty   = duty_held;
    if (!sum_ok) begin
      q_entry.kind = cfp_pkg::KIND_ERROR;
    end else if (is_query) begin
      q_entry.kind = cfp_pkg::KIND_REPLY;
    end else if (is_fan) begin
      q_entry.kind   = cfp_pkg::KIND_FAN;
      q_entry.fan_on = 1'b1;
      q_entry.duty   = clamped;
    end
  end

  assign q_push = accept && (parse_phase == PH_CHECK);

  // Advance the parse phase
  always_comb begin
    parse_phase_next = parse_phase;
    case (parse_phase)
      PH_HUNT1: begin
        if (byte_value == header_first) parse_phase_next = PH_HUNT2;
      end
      PH_HUNT2: begin
        if (byte_value == header_second)     parse_phase_next = PH_LEN;
        else if (byte_value == header_first) parse_phase_next = PH_HUNT2;
        else                                 parse_phase_next = PH_HUNT1;
      end
      PH_LEN: begin
        parse_phase_next = (byte_value == 8'd0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (count_inc == frame_length) parse_phase_next = PH_CHECK;
      end
      PH_CHECK: parse_phase_next = PH_HUNT1;
      default:  parse_phase_next = PH_HUNT1;
    endcase
  end

  // Update parser and fan state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= PH_HUNT1;
      frame_length  <= 8'd0;
      payload_count <= 8'd0;
      running_sum   <= 8'd0;
      command_byte  <= 8'd0;
      data_byte     <= 8'd0;
      fan_power     <= 1'b0;
      duty_held     <= 7'd0;
    end else if (accept) begin
      parse_phase <= parse_phase_next;
      case (parse_phase)
        PH_LEN: begin
          frame_length  <= byte_value;
          payload_count <= 8'd0;
          running_sum   <= 8'd0;
          command_byte  <= 8'd0;
          data_byte     <= 8'd0;
        end
        PH_PAYLOAD: begin
          running_sum   <= running_sum + byte_value;
          payload_count <= count_inc;
          if (payload_count == 8'd0)      command_byte <= byte_value;
          else if (payload_count == 8'd1) data_byte    <= byte_value;
        end
        PH_CHECK: begin
          fan_power <= q_entry.fan_on;
          duty_held <= q_entry.duty;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/cfp_queue.sv
// Short command queue between the front end and the result sequencer.
// Depends on cfp_pkg.
`timescale 1ns / 1ps

module cfp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cfp_pkg::cmd_entry_t  push_entry,
  input  logic                 pop,
  output cfp_pkg::cmd_entry_t  head,
  output cfp_pkg::q_status_t   status
);

  cfp_pkg::cmd_entry_t          entries [0:cfp_pkg::QUEUE_DEPTH-1];
  logic [cfp_pkg::QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [cfp_pkg::QPTR_BITS:0]   count;
  logic                          do_push, do_pop;

  assign status.empty = (count == '0);
  assign status.full  = (count == (cfp_pkg::QPTR_BITS+1)'(cfp_pkg::QUEUE_DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_entry;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/cfp_back.sv
// Back end: expands queued commands into result items and holds the
// output register. Depends on cfp_pkg.
`timescale 1ns / 1ps

module cfp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  cfp_pkg::cmd_entry_t           head,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  logic                          pop,
  output logic                          empty,
  output logic [1:0]                    result_kind,
  output logic [7:0]                    reply_byte,
  output logic                          last,
  output logic                          fan_on,
  output logic [6:0]                    duty_percent,
  output logic [cfp_pkg::DUTY_BITS-1:0] duty_code
);

  logic                          out_valid;
  logic [cfp_pkg::BEAT_BITS-1:0] beat;
  logic                          load, take, is_reply;

  assign empty    = !out_valid;
  assign load     = !out_valid || pop;
  assign take     = load && !q_empty;
  assign is_reply = (head.kind == cfp_pkg::KIND_REPLY);
  assign q_pop    = take && (!is_reply || (beat == cfp_pkg::REPLY_LAST));

  // Step through reply beats; hold control under reset
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat      <= '0;
    end else if (take) begin
      out_valid <= 1'b1;
      if (is_reply) beat <= (beat == cfp_pkg::REPLY_LAST) ? '0 : beat + 1'b1;
    end else if (load) begin
      out_valid <= 1'b0;
    end
  end

  // Load the output register from the queue head
  always_ff @(posedge clk) begin
    if (take) begin
      result_kind  <= head.kind;
      reply_byte   <= is_reply ? cfp_pkg::reply_byte_of(beat) : 8'h00;
      last         <= !is_reply || (beat == cfp_pkg::REPLY_LAST);
      fan_on       <= head.fan_on;
      duty_percent <= head.duty;
      duty_code    <= cfp_pkg::duty_code_of(head.duty);
    end
  end

endmodule

>>> hw/rtl/checksum_frame_parser_fan_command.sv
// Byte stream frame parser with fan command decoding: top level.
// Depends on cfp_pkg, cfp_front, cfp_queue and cfp_back.
//
// Bytes enter one per cycle through push/full while full is low and are
// parsed as H1 H2 LEN PAYLOAD CHK; the command of a frame is queued on its
// checksum byte and its result items leave one per cycle through empty/pop
// while pop is high. The first one reaches the result ports after the queue
// has stored the command and the output register has loaded it from the
// queue head. A query frame yields six reply items from the back-end beat
// sequencer, every other frame one item. The four-entry command queue between
// parser and sequencer sets how far output stalls may run before full rises;
// full depends only on queue occupancy. Configuration writes take effect at
// the next clock edge.
`timescale 1ns / 1ps

module checksum_frame_parser_fan_command (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    byte_value,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    result_kind,
  output logic [7:0]                    reply_byte,
  output logic                          last,
  output logic                          fan_on,
  output logic [6:0]                    duty_percent,
  output logic [cfp_pkg::DUTY_BITS-1:0] duty_code
);

  cfp_pkg::cmd_entry_t push_entry, head;
  cfp_pkg::q_status_t  q_status;
  logic                q_push, q_pop, accept;

  assign full   = q_status.full;
  assign accept = push && !q_status.full;

  // Parse and classify
  cfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .byte_value (byte_value),
    .q_push     (q_push),
    .q_entry    (push_entry)
  );

  // Decouple parser from result sequencer
  cfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .status     (q_status)
  );

  // Expand commands into result items
  cfp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_status.empty),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .result_kind  (result_kind),
    .reply_byte   (reply_byte),
    .last         (last),
    .fan_on       (fan_on),
    .duty_percent (duty_percent),
    .duty_code    (duty_code)
  );

endmodule

>>> hw/rtl/checksum_frame_parser_fan_command_checker.sv
// Port-level checker for the frame parser, bound to the top level.
// Depends on cfp_pkg and checksum_frame_parser_fan_command_defines.svh.
`timescale 1ns / 1ps
`include "checksum_frame_parser_fan_command_defines.svh"

module checksum_frame_parser_fan_command_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          empty,
  input logic                          pop,
  input logic [1:0]                    result_kind,
  input logic [7:0]                    reply_byte,
  input logic                          last,
  input logic                          fan_on,
  input logic [6:0]                    duty_percent,
  input logic [cfp_pkg::DUTY_BITS-1:0] duty_code
);

  logic                              single_item;
  logic                              fan_off_item;
  logic                              duty_zero;
  logic                              stall;
  logic [cfp_pkg::DUTY_BITS+18:0]    out_bits;

  assign single_item  = !empty && (result_kind != cfp_pkg::KIND_REPLY);
  assign fan_off_item = !empty && !fan_on;
  assign duty_zero    = (duty_percent == 7'd0) && (duty_code == '0);
  assign stall        = !empty && !pop;
  assign out_bits     = {result_kind, reply_byte, last, fan_on, duty_percent, duty_code};

  // Only reply items carry a byte, and every other item ends its burst
  `CFP_ASSERT_NOW(a_reply_byte_zero, single_item, reply_byte == 8'h00, "reply byte on single item")
  `CFP_ASSERT_NOW(a_single_is_last, single_item, last, "single item without last")

  // Duty stays zero until the fan is first switched on
  `CFP_ASSERT_NOW(a_fan_off_duty_zero, fan_off_item, duty_zero, "duty set while fan off")

  // Hold a stalled result
  `CFP_ASSERT_NEXT(a_stall_hold, stall, !empty && $stable(out_bits), "stalled result changed")

endmodule

bind checksum_frame_parser_fan_command checksum_frame_parser_fan_command_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .empty        (empty),
  .pop          (pop),
  .result_kind  (result_kind),
  .reply_byte   (reply_byte),
  .last         (last),
  .fan_on       (fan_on),
  .duty_percent (duty_percent),
  .duty_code    (duty_code)
);

>>> tb/sv/checksum_frame_parser_fan_command_tb.sv
// Self-checking testbench for the checksum frame parser with fan commands.
// Depends on cfp_pkg and checksum_frame_parser_fan_command; bytes go in through
// push/full, results are checked against a built-in frame parser predictor.
`timescale 1ns / 1ps

module checksum_frame_parser_fan_command_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [7:0] REPLY_SEQ [0:5] = '{8'hAA, 8'h66, 8'h02, 8'h80, 8'h01, 8'h81};

  typedef enum logic [2:0] {
    SEEK_FIRST,
    SEEK_SECOND,
    TAKE_LEN,
    TAKE_PAYLOAD,
    TAKE_SUM
  } parse_phase_t;

  typedef struct packed {
    cfp_pkg::kind_t                kind;
    logic [7:0]                    rbyte;
    logic                          fin;
    logic                          fan;
    logic [6:0]                    pct;
    logic [cfp_pkg::DUTY_BITS-1:0] code;
  } frame_result_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [1:0]                    cfg_index;
  logic [7:0]                    cfg_data;
  logic                          push;
  logic                          full;
  logic [7:0]                    byte_value;
  logic                          empty;
  logic                          pop;
  logic [1:0]                    result_kind;
  logic [7:0]                    reply_byte;
  logic                          last;
  logic                          fan_on;
  logic [6:0]                    duty_percent;
  logic [cfp_pkg::DUTY_BITS-1:0] duty_code;

  // Stream bytes waiting to be sent and results owed by the block
  logic [7:0]    stream_bytes [$];
  frame_result_t owed_results [$];

  // Predictor copy of registers and parse state
  logic [7:0]   hdr_first;
  logic [7:0]   hdr_second;
  logic [6:0]   duty_cap;
  parse_phase_t phase;
  logic [7:0]   length_seen;
  logic [7:0]   pay_count;
  logic [7:0]   run_sum;
  logic [7:0]   cmd_byte;
  logic [7:0]   dat_byte;
  logic         fan_state;
  logic [6:0]   duty_state;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int cycles;
  int bytes_queued;

  checksum_frame_parser_fan_command dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .byte_value   (byte_value),
    .empty        (empty),
    .pop          (pop),
    .result_kind  (result_kind),
    .reply_byte   (reply_byte),
    .last         (last),
    .fan_on       (fan_on),
    .duty_percent (duty_percent),
    .duty_code    (duty_code)
  );

  always #5 clk = ~clk;

  // Record one result the block owes, carrying the fan state after it
  function automatic void queue_result(input cfp_pkg::kind_t kind, input logic [7:0] rb,
                                       input logic fin);
    frame_result_t r;
    r.kind  = kind;
    r.rbyte = rb;
    r.fin   = fin;
    r.fan   = fan_state;
    r.pct   = duty_state;
    r.code  = cfp_pkg::DUTY_BITS'((int'(duty_state) * cfp_pkg::DUTY_FULL) / 100);
    owed_results.push_back(r);
  endfunction

  // Advance the frame parser by one transferred byte
  function automatic void parse_byte(input logic [7:0] b);
    logic [6:0] lim;
    logic [6:0] d;
    case (phase)
      SEEK_FIRST: begin
        if (b == hdr_first) phase = SEEK_SECOND;
      end
      SEEK_SECOND: begin
        if (b == hdr_second) phase = TAKE_LEN;
        else if (b != hdr_first) phase = SEEK_FIRST;
      end
      TAKE_LEN: begin
        length_seen = b;
        pay_count   = '0;
        run_sum     = '0;
        cmd_byte    = '0;
        dat_byte    = '0;
        phase       = (b == 8'd0) ? TAKE_SUM : TAKE_PAYLOAD;
      end
      TAKE_PAYLOAD: begin
        run_sum = run_sum + b;
        if (pay_count == 8'd0) cmd_byte = b;
        else if (pay_count == 8'd1) dat_byte = b;
        pay_count = pay_count + 8'd1;
        if (pay_count == length_seen) phase = TAKE_SUM;
      end
      TAKE_SUM: begin
        phase = SEEK_FIRST;
        if (b != run_sum) begin
          queue_result(cfp_pkg::KIND_ERROR, 8'h00, 1'b1);
        end else if (length_seen == cfp_pkg::PAYLOAD_LEN_CMD &&
                     cmd_byte == cfp_pkg::CMD_QUERY && dat_byte == 8'h00) begin
          for (int i = 0; i < 6; i++)
            queue_result(cfp_pkg::KIND_REPLY, REPLY_SEQ[i], i == 5);
        end else if (length_seen == cfp_pkg::PAYLOAD_LEN_CMD &&
                     cmd_byte == cfp_pkg::CMD_FAN_SET) begin
          lim = (duty_cap > cfp_pkg::DUTY_MAX) ? cfp_pkg::DUTY_MAX : duty_cap;
          d = (dat_byte > {1'b0, lim}) ? lim : dat_byte[6:0];
          fan_state  = 1'b1;
          duty_state = d;
          queue_result(cfp_pkg::KIND_FAN, 8'h00, 1'b1);
        end else begin
          queue_result(cfp_pkg::KIND_STATUS, 8'h00, 1'b1);
        end
      end
      default: phase = SEEK_FIRST;
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Compare one transferred result with the oldest owed one
  task automatic check_result();
    frame_result_t exp;
    if (owed_results.size() == 0) begin
      flag_mismatch($sformatf("result with nothing owed, kind %0d", result_kind));
    end else begin
      exp = owed_results.pop_front();
      if (result_kind != exp.kind)
        flag_mismatch($sformatf("result_kind %0d, want %0d", result_kind, exp.kind));
      if (reply_byte != exp.rbyte)
        flag_mismatch($sformatf("reply_byte %h, want %h", reply_byte, exp.rbyte));
      if (last != exp.fin)
        flag_mismatch($sformatf("last %0b, want %0b", last, exp.fin));
      if (fan_on != exp.fan)
        flag_mismatch($sformatf("fan_on %0b, want %0b", fan_on, exp.fan));
      if (duty_percent != exp.pct)
        flag_mismatch($sformatf("duty_percent %0d, want %0d", duty_percent, exp.pct));
      if (duty_code != exp.code)
        flag_mismatch($sformatf("duty_code %0d, want %0d", duty_code, exp.code));
    end
  endtask

  // Driver: present the next byte, predict on each transfer
  always @(posedge clk) begin
    if (rst) begin
      push       <= 1'b0;
      byte_value <= '0;
    end else begin
      if (push && !full) begin
        parse_byte(byte_value);
        void'(stream_bytes.pop_front());
      end
      if (stream_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        push       <= 1'b1;
        byte_value <= stream_bytes[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: check each transferred result, stall at random
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result();
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("checksum_frame_parser_fan_command verification failed");
      $finish;
    end
  end

  function automatic void send(input logic [7:0] b);
    stream_bytes.push_back(b);
    bytes_queued++;
  endfunction

  // Queue one frame under the current headers; payload past two bytes is random
  function automatic void queue_frame(input int len, input logic [7:0] cmd,
                                      input logic [7:0] dat, input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'h00;
    send(hdr_first);
    send(hdr_second);
    send(8'(len));
    for (int i = 0; i < len; i++) begin
      b = (i == 0) ? cmd : (i == 1) ? dat : 8'($urandom);
      sum = sum + b;
      send(b);
    end
    if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
    send(sum);
  endfunction

  // Mostly well-formed frames with random content, some noise and broken frames
  function automatic void random_traffic(input int n_bytes);
    int stop_at;
    int r;
    int len;
    stop_at = bytes_queued + n_bytes;
    while (bytes_queued < stop_at) begin
      r = $urandom_range(99);
      if (r < 15) begin
        queue_frame(2, cfp_pkg::CMD_QUERY, 8'h00, $urandom_range(9) == 0);
      end else if (r < 45) begin
        queue_frame(2, cfp_pkg::CMD_FAN_SET,
                    $urandom_range(1) ? 8'($urandom_range(127)) : 8'($urandom),
                    $urandom_range(9) == 0);
      end else if (r < 60) begin
        queue_frame(2, 8'($urandom), 8'($urandom), $urandom_range(7) == 0);
      end else if (r < 75) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(6);
        queue_frame(len, 8'($urandom), 8'($urandom), $urandom_range(7) == 0);
      end else if (r < 88) begin
        repeat ($urandom_range(1, 3)) send(8'($urandom));
      end else begin
        // Broken frame: header, maybe a length, cut short
        send(hdr_first);
        if ($urandom_range(1)) send(hdr_second);
        if ($urandom_range(1)) send(8'($urandom_range(1, 4)));
      end
    end
  endfunction

  // Hold until every byte is sent and every owed result has come back
  task automatic wait_drained();
    while (stream_bytes.size() > 0 || push || owed_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      cfp_pkg::REG_HEADER_FIRST:  hdr_first  = data;
      cfp_pkg::REG_HEADER_SECOND: hdr_second = data;
      cfp_pkg::REG_DUTY_LIMIT:    duty_cap   = data[6:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    mismatches    = 0;
    cycles        = 0;
    bytes_queued  = 0;
    hdr_first     = cfp_pkg::HEADER_FIRST_RST;
    hdr_second    = cfp_pkg::HEADER_SECOND_RST;
    duty_cap      = cfp_pkg::DUTY_LIMIT_RST;
    phase         = SEEK_FIRST;
    length_seen   = '0;
    pay_count     = '0;
    run_sum       = '0;
    cmd_byte      = '0;
    dat_byte      = '0;
    fan_state     = 1'b0;
    duty_state    = '0;
    send_idle_pct = 22;
    recv_idle_pct = 77;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: repeated first header into a query, clamped fan set,
    // zero length frame, bad checksum, stray bytes
    send(hdr_first);
    queue_frame(2, cfp_pkg::CMD_QUERY, 8'h00, 1'b0);
    queue_frame(2, cfp_pkg::CMD_FAN_SET, 8'hFF, 1'b0);
    queue_frame(0, 8'h00, 8'h00, 1'b0);
    queue_frame(1, 8'h05, 8'h00, 1'b1);
    send(8'h66);
    send(8'h00);
    random_traffic(115);
    wait_drained();

    // Extreme headers, zero duty limit, write to the unused index
    write_reg(cfp_pkg::REG_HEADER_FIRST, 8'h00);
    write_reg(cfp_pkg::REG_HEADER_SECOND, 8'hFF);
    write_reg(cfp_pkg::REG_DUTY_LIMIT, 8'h00);
    write_reg(REG_UNUSED, 8'h5A);
    random_traffic(55);
    // Sender pauses here until the block has returned everything
    wait_drained();
    random_traffic(60);
    wait_drained();

    // Swapped headers, limit above 100 with the high data bit set
    send_idle_pct = 77;
    recv_idle_pct = 22;
    write_reg(cfp_pkg::REG_HEADER_FIRST, 8'hFF);
    write_reg(cfp_pkg::REG_HEADER_SECOND, 8'h00);
    write_reg(cfp_pkg::REG_DUTY_LIMIT, 8'hFF);
    random_traffic(115);
    wait_drained();

    // Mid-range settings at full rate
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(cfp_pkg::REG_HEADER_FIRST, 8'h5A);
    write_reg(cfp_pkg::REG_HEADER_SECOND, 8'hA5);
    write_reg(cfp_pkg::REG_DUTY_LIMIT, 8'h32);
    random_traffic(115);
    wait_drained();

    if (mismatches == 0) begin
      $display("checksum_frame_parser_fan_command verification clean");
    end else begin
      $display("checksum_frame_parser_fan_command verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/cfp_pkg.sv
hw/rtl/cfp_front.sv
hw/rtl/cfp_queue.sv
hw/rtl/cfp_back.sv
hw/rtl/checksum_frame_parser_fan_command.sv
hw/rtl/checksum_frame_parser_fan_command_checker.sv
tb/sv/checksum_frame_parser_fan_command_tb.sv
